[rtl/pqs_pkg.sv]
`timescale 1ns / 1ps

package pqs_pkg;

  localparam int CoordW = 32;
  localparam int WidthW = 31;
  localparam int CfgIdxW = 2;
  localparam int VinW = 64;
  localparam int MagW = 63;

  localparam logic [WidthW-1:0] WIDTH_RESET = 31'd65536;
  localparam logic signed [CoordW-1:0] UP_X_RESET = 32'sd0;
  localparam logic signed [CoordW-1:0] UP_Y_RESET = 32'sd65536;
  localparam logic signed [CoordW-1:0] UP_Z_RESET = 32'sd0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH, CFG_UP_X, CFG_UP_Y, CFG_UP_Z
  } cfg_idx_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD_F, OP_LOAD_UP, OP_LOAD_D0, OP_LOAD_D1, OP_ABS, OP_SCALE,
    OP_SAVE_FS, OP_SAVE_US, OP_CROSS_MUL, OP_CROSS_ACC, OP_SQ_MUL, OP_SQ_ACC,
    OP_SQRT_INIT, OP_SQRT_STEP, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_STORE,
    OP_ZERO_U, OP_OFF_MUL, OP_OFF_ACC, OP_EMIT, OP_PEND, OP_COMMIT
  } op_t;

  typedef enum logic [1:0] {DST_R, DST_F, DST_D} dst_t;

  typedef enum logic [3:0] {
    V_BACK_R, V_BACK_L, V_START_R, V_START_L, V_BEND_R, V_BEND_L,
    V_PEND_R, V_PEND_L, V_END_R, V_END_L
  } vert_t;

  typedef enum logic [4:0] {
    S_IDLE, S_COMMIT, S_LOAD, S_CROSS, S_ABS, S_SCALE, S_SAVE, S_SQ,
    S_SQRT_INIT, S_SQRT, S_DIV_INIT, S_DIV, S_DIV_STORE, S_ZERO, S_OFF,
    S_EMIT, S_PEND
  } state_t;

  typedef enum logic [2:0] {PH_FS, PH_US, PH_R, PH_F, PH_D0, PH_D1} phase_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] idx;
    dst_t       dst;
    vert_t      vert;
    logic       accept;
  } cmd_t;

  typedef struct packed {
    logic scale_done;
    logic scale_zero;
    logic out_busy;
    logic fin;
  } sts_t;

endpackage

[rtl/polyline_quad_strip_extruder.sv]
`timescale 1ns / 1ps

// Ribbon extruder: takes one polyline point per item (Q16.16) and emits
// quad-strip vertices as right/left pairs with mitered joints; tlast on the
// input closes the line, tlast on the output marks the strip's last vertex.
// The block takes one point at a time: in_tready stays low until a point is
// through, including any time a vertex waits on out_tready, and a
// zero vector skips the square root and divider. The time is set by the
// shared sequencer that runs block scaling (one bit shift a cycle), one
// multiplier for the cross product, squares and offsets, a 32-step square root
// and a 31-step divider per component, for two normalizations on the second
// point and four on every later one; vertices leave through a one-item output
// register.
module polyline_quad_strip_extruder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [3*pqs_pkg::CoordW-1:0] in_tdata,  // point_x, point_y, point_z
  input  logic                         in_tlast,  // final_point
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [3*pqs_pkg::CoordW-1:0] out_tdata, // vert_x, vert_y, vert_z
  output logic [0:0]                   out_tuser, // left_side
  output logic                         out_tlast, // strip_end
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pqs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [31:0]                  cfg_data
);

  pqs_pkg::cmd_t cmd;
  pqs_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  pqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pqs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_point  (in_tdata),
    .in_final  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_vert  (out_tdata),
    .out_left  (out_tuser[0]),
    .out_end   (out_tlast)
  );

endmodule

[rtl/pqs_ctrl.sv]
`timescale 1ns / 1ps

module pqs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pqs_pkg::sts_t sts,
  output pqs_pkg::cmd_t cmd
);

  pqs_pkg::state_t state_r, state_nxt;
  pqs_pkg::phase_t phase_r, phase_nxt;
  pqs_pkg::vert_t  vert_r, vert_nxt;
  logic [1:0] seen_r, seen_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       half_r, half_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pqs_pkg::S_IDLE;
      phase_r <= pqs_pkg::PH_FS;
      vert_r  <= pqs_pkg::V_BACK_R;
      seen_r  <= 2'd0;
      cnt_r   <= 5'd0;
      idx_r   <= 2'd0;
      half_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      vert_r  <= vert_nxt;
      seen_r  <= seen_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      half_r  <= half_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    vert_nxt  = vert_r;
    seen_nxt  = seen_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    half_nxt  = half_r;
    unique case (state_r)
      pqs_pkg::S_IDLE: begin
        if (in_valid) begin
          if (seen_r == 2'd0) begin
            state_nxt = pqs_pkg::S_COMMIT;
          end else begin
            phase_nxt = pqs_pkg::PH_FS;
            state_nxt = pqs_pkg::S_LOAD;
          end
        end
      end
      pqs_pkg::S_COMMIT: begin
        seen_nxt  = sts.fin ? 2'd0 : ((seen_r == 2'd0) ? 2'd1 : 2'd2);
        state_nxt = pqs_pkg::S_IDLE;
      end
      pqs_pkg::S_LOAD: state_nxt = pqs_pkg::S_ABS;
      pqs_pkg::S_CROSS: begin
        half_nxt = !half_r;
        if (half_r) begin
          cnt_nxt = cnt_r + 5'd1;
          if (cnt_r == 5'd5) state_nxt = pqs_pkg::S_ABS;
        end
      end
      pqs_pkg::S_ABS: state_nxt = pqs_pkg::S_SCALE;
      pqs_pkg::S_SCALE: begin
        if (sts.scale_done) begin
          cnt_nxt  = 5'd0;
          half_nxt = 1'b0;
          if (phase_r == pqs_pkg::PH_FS || phase_r == pqs_pkg::PH_US) begin
            state_nxt = pqs_pkg::S_SAVE;
          end else if (sts.scale_zero) begin
            state_nxt = pqs_pkg::S_ZERO;
          end else begin
            state_nxt = pqs_pkg::S_SQ;
          end
        end
      end
      pqs_pkg::S_SAVE: begin
        if (phase_r == pqs_pkg::PH_FS) begin
          phase_nxt = pqs_pkg::PH_US;
          state_nxt = pqs_pkg::S_LOAD;
        end else begin
          phase_nxt = pqs_pkg::PH_R;
          cnt_nxt   = 5'd0;
          half_nxt  = 1'b0;
          state_nxt = pqs_pkg::S_CROSS;
        end
      end
      pqs_pkg::S_SQ: begin
        half_nxt = !half_r;
        if (half_r) begin
          cnt_nxt = cnt_r + 5'd1;
          if (cnt_r == 5'd2) state_nxt = pqs_pkg::S_SQRT_INIT;
        end
      end
      pqs_pkg::S_SQRT_INIT: begin
        cnt_nxt   = 5'd0;
        state_nxt = pqs_pkg::S_SQRT;
      end
      pqs_pkg::S_SQRT: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          idx_nxt   = 2'd0;
          state_nxt = pqs_pkg::S_DIV_INIT;
        end
      end
      pqs_pkg::S_DIV_INIT: begin
        cnt_nxt   = 5'd0;
        state_nxt = pqs_pkg::S_DIV;
      end
      pqs_pkg::S_DIV: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd30) state_nxt = pqs_pkg::S_DIV_STORE;
      end
      pqs_pkg::S_DIV_STORE: begin
        if (idx_r == 2'd2) begin
          cnt_nxt   = 5'd0;
          half_nxt  = 1'b0;
          state_nxt = pqs_pkg::S_OFF;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = pqs_pkg::S_DIV_INIT;
        end
      end
      pqs_pkg::S_ZERO: begin
        cnt_nxt   = 5'd0;
        half_nxt  = 1'b0;
        state_nxt = pqs_pkg::S_OFF;
      end
      pqs_pkg::S_OFF: begin
        half_nxt = !half_r;
        if (half_r) begin
          cnt_nxt = cnt_r + 5'd1;
          if (cnt_r == 5'd2) begin
            unique case (phase_r)
              pqs_pkg::PH_R: begin
                phase_nxt = pqs_pkg::PH_F;
                state_nxt = pqs_pkg::S_LOAD;
              end
              pqs_pkg::PH_F: begin
                if (seen_r == 2'd1) begin
                  vert_nxt  = pqs_pkg::V_BACK_R;
                  state_nxt = pqs_pkg::S_EMIT;
                end else begin
                  phase_nxt = pqs_pkg::PH_D0;
                  state_nxt = pqs_pkg::S_LOAD;
                end
              end
              pqs_pkg::PH_D0: begin
                vert_nxt  = pqs_pkg::V_BEND_R;
                state_nxt = pqs_pkg::S_EMIT;
              end
              default: begin
                vert_nxt  = pqs_pkg::V_BEND_L;
                state_nxt = pqs_pkg::S_EMIT;
              end
            endcase
          end
        end
      end
      pqs_pkg::S_EMIT: begin
        if (!sts.out_busy) begin
          unique case (vert_r)
            pqs_pkg::V_BACK_R:  vert_nxt = pqs_pkg::V_BACK_L;
            pqs_pkg::V_BACK_L:  vert_nxt = pqs_pkg::V_START_R;
            pqs_pkg::V_START_R: vert_nxt = pqs_pkg::V_START_L;
            pqs_pkg::V_START_L: state_nxt = pqs_pkg::S_PEND;
            pqs_pkg::V_BEND_R: begin
              phase_nxt = pqs_pkg::PH_D1;
              state_nxt = pqs_pkg::S_LOAD;
            end
            pqs_pkg::V_BEND_L:  state_nxt = pqs_pkg::S_PEND;
            pqs_pkg::V_PEND_R:  vert_nxt = pqs_pkg::V_PEND_L;
            pqs_pkg::V_PEND_L:  vert_nxt = pqs_pkg::V_END_R;
            pqs_pkg::V_END_R:   vert_nxt = pqs_pkg::V_END_L;
            default:            state_nxt = pqs_pkg::S_COMMIT;
          endcase
        end
      end
      default: begin
        // S_PEND
        if (sts.fin) begin
          vert_nxt  = pqs_pkg::V_PEND_R;
          state_nxt = pqs_pkg::S_EMIT;
        end else begin
          state_nxt = pqs_pkg::S_COMMIT;
        end
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd.op     = pqs_pkg::OP_NOP;
    cmd.idx    = cnt_r[2:0];
    cmd.dst    = pqs_pkg::DST_D;
    cmd.vert   = vert_r;
    cmd.accept = 1'b0;
    in_ready   = 1'b0;
    if (phase_r == pqs_pkg::PH_R) cmd.dst = pqs_pkg::DST_R;
    else if (phase_r == pqs_pkg::PH_F) cmd.dst = pqs_pkg::DST_F;
    unique case (state_r)
      pqs_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      pqs_pkg::S_COMMIT: cmd.op = pqs_pkg::OP_COMMIT;
      pqs_pkg::S_LOAD: begin
        unique case (phase_r)
          pqs_pkg::PH_US: cmd.op = pqs_pkg::OP_LOAD_UP;
          pqs_pkg::PH_D0: cmd.op = pqs_pkg::OP_LOAD_D0;
          pqs_pkg::PH_D1: cmd.op = pqs_pkg::OP_LOAD_D1;
          default:        cmd.op = pqs_pkg::OP_LOAD_F;
        endcase
      end
      pqs_pkg::S_CROSS: cmd.op = half_r ? pqs_pkg::OP_CROSS_ACC : pqs_pkg::OP_CROSS_MUL;
      pqs_pkg::S_ABS:   cmd.op = pqs_pkg::OP_ABS;
      pqs_pkg::S_SCALE: cmd.op = pqs_pkg::OP_SCALE;
      pqs_pkg::S_SAVE: begin
        cmd.op = (phase_r == pqs_pkg::PH_FS) ? pqs_pkg::OP_SAVE_FS : pqs_pkg::OP_SAVE_US;
      end
      pqs_pkg::S_SQ:        cmd.op = half_r ? pqs_pkg::OP_SQ_ACC : pqs_pkg::OP_SQ_MUL;
      pqs_pkg::S_SQRT_INIT: cmd.op = pqs_pkg::OP_SQRT_INIT;
      pqs_pkg::S_SQRT:      cmd.op = pqs_pkg::OP_SQRT_STEP;
      pqs_pkg::S_DIV_INIT: begin
        cmd.op  = pqs_pkg::OP_DIV_INIT;
        cmd.idx = {1'b0, idx_r};
      end
      pqs_pkg::S_DIV: cmd.op = pqs_pkg::OP_DIV_STEP;
      pqs_pkg::S_DIV_STORE: begin
        cmd.op  = pqs_pkg::OP_DIV_STORE;
        cmd.idx = {1'b0, idx_r};
      end
      pqs_pkg::S_ZERO: cmd.op = pqs_pkg::OP_ZERO_U;
      pqs_pkg::S_OFF:  cmd.op = half_r ? pqs_pkg::OP_OFF_ACC : pqs_pkg::OP_OFF_MUL;
      pqs_pkg::S_EMIT: if (!sts.out_busy) cmd.op = pqs_pkg::OP_EMIT;
      default:         cmd.op = pqs_pkg::OP_PEND;
    endcase
  end

endmodule

[rtl/pqs_dp.sv]
`timescale 1ns / 1ps

module pqs_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pqs_pkg::cmd_t                 cmd,
  output pqs_pkg::sts_t                 sts,
  input  logic [3*pqs_pkg::CoordW-1:0]  in_point,
  input  logic                          in_final,
  input  logic                          cfg_valid,
  input  logic [pqs_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [31:0]                   cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3*pqs_pkg::CoordW-1:0]  out_vert,
  output logic                          out_left,
  output logic                          out_end
);

  localparam int CW = pqs_pkg::CoordW;
  localparam int VW = pqs_pkg::VinW;
  localparam int MW = pqs_pkg::MagW;
  localparam int SW = CW + 3;

  function automatic logic signed [CW-1:0] sat32(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = SW'(32'sh7fffffff);
    lo = -SW'(33'sh080000000);
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[CW-1:0];
  endfunction

  logic [pqs_pkg::WidthW-1:0] width_r;
  logic signed [CW-1:0] up_r [3];
  logic signed [CW-1:0] p_r [3];
  logic signed [CW-1:0] prev_r [3];
  logic signed [CW-1:0] pend_r [6];
  logic                 fin_r;
  logic signed [VW-1:0] vin_r [3];
  logic [MW-1:0]        mag_r [3];
  logic                 neg_r [3];
  logic signed [30:0]   fs_r [3];
  logic signed [30:0]   us_r [3];
  logic signed [63:0]   prod_r;
  logic [61:0]          sumsq_r;
  logic [61:0]          sqn_r;
  logic [62:0]          sqres_r;
  logic [62:0]          sqbit_r;
  logic [60:0]          rem_r;
  logic [60:0]          den_r;
  logic [30:0]          q_r;
  logic signed [CW-1:0] u_r [3];
  logic signed [CW-1:0] rof_r [3];
  logic signed [CW-1:0] fof_r [3];
  logic signed [CW-1:0] dof_r [3];
  logic                 out_valid_r;
  logic signed [CW-1:0] overt_r [3];
  logic                 oleft_r;
  logic                 oend_r;

  logic [1:0]           k;
  logic [MW-1:0]        or_m;
  logic                 scale_zero;
  logic                 scale_done;
  logic signed [31:0]   mul_a;
  logic signed [31:0]   mul_b;
  logic signed [63:0]   prod_nxt;
  logic [63:0]          sq_try;
  logic [MW-1:0]        mag_sel;
  logic signed [63:0]   off_sum;
  logic signed [SW-1:0] vsum [3];
  logic                 vleft;
  logic                 vend;
  logic [1:0]           ck;

  assign k = cmd.idx[1:0];
  assign mag_sel = mag_r[k];
  assign or_m = mag_r[0] | mag_r[1] | mag_r[2];
  assign scale_zero = (or_m == '0);
  assign scale_done = scale_zero || (!(|or_m[MW-1:30]) && or_m[29]);
  assign sq_try = {1'b0, sqres_r} + {1'b0, sqbit_r};
  assign off_sum = prod_r + 64'sd1073741824;
  assign ck = cmd.idx[2:1];

  assign sts.scale_done = scale_done;
  assign sts.scale_zero = scale_zero;
  assign sts.out_busy   = out_valid_r && !out_ready;
  assign sts.fin        = fin_r;

  // multiplier operands; the cross product pairs follow fs[a]*us[b]
  always_comb begin
    mul_a = 32'sd0;
    mul_b = 32'sd0;
    unique case (cmd.op)
      pqs_pkg::OP_CROSS_MUL: begin
        unique case (cmd.idx)
          3'd0: begin mul_a = 32'(fs_r[1]); mul_b = 32'(us_r[2]); end
          3'd1: begin mul_a = 32'(fs_r[2]); mul_b = 32'(us_r[1]); end
          3'd2: begin mul_a = 32'(fs_r[2]); mul_b = 32'(us_r[0]); end
          3'd3: begin mul_a = 32'(fs_r[0]); mul_b = 32'(us_r[2]); end
          3'd4: begin mul_a = 32'(fs_r[0]); mul_b = 32'(us_r[1]); end
          default: begin mul_a = 32'(fs_r[1]); mul_b = 32'(us_r[0]); end
        endcase
      end
      pqs_pkg::OP_SQ_MUL: begin
        mul_a = $signed({2'b00, mag_sel[29:0]});
        mul_b = $signed({2'b00, mag_sel[29:0]});
      end
      pqs_pkg::OP_OFF_MUL: begin
        mul_a = u_r[k];
        mul_b = $signed({1'b0, width_r});
      end
      default: ;
    endcase
    prod_nxt = 64'(mul_a) * 64'(mul_b);
  end

  // vertex terms
  always_comb begin
    vleft = 1'b0;
    vend  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      unique case (cmd.vert)
        pqs_pkg::V_BACK_R:  vsum[i] = SW'(prev_r[i]) - SW'(fof_r[i]) + SW'(rof_r[i]);
        pqs_pkg::V_BACK_L:  vsum[i] = SW'(prev_r[i]) - SW'(fof_r[i]) - SW'(rof_r[i]);
        pqs_pkg::V_START_R: vsum[i] = SW'(prev_r[i]) + SW'(rof_r[i]);
        pqs_pkg::V_START_L: vsum[i] = SW'(prev_r[i]) - SW'(rof_r[i]);
        pqs_pkg::V_BEND_R,
        pqs_pkg::V_BEND_L:  vsum[i] = SW'(prev_r[i]) + SW'(dof_r[i]);
        pqs_pkg::V_PEND_R:  vsum[i] = SW'(pend_r[i]);
        pqs_pkg::V_PEND_L:  vsum[i] = SW'(pend_r[3+i]);
        pqs_pkg::V_END_R:   vsum[i] = SW'(p_r[i]) + SW'(fof_r[i]) + SW'(rof_r[i]);
        default:            vsum[i] = SW'(p_r[i]) + SW'(fof_r[i]) - SW'(rof_r[i]);
      endcase
    end
    unique case (cmd.vert)
      pqs_pkg::V_BACK_L, pqs_pkg::V_START_L, pqs_pkg::V_BEND_L,
      pqs_pkg::V_PEND_L: vleft = 1'b1;
      pqs_pkg::V_END_L: begin
        vleft = 1'b1;
        vend  = 1'b1;
      end
      default: vleft = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= pqs_pkg::WIDTH_RESET;
      up_r[0]     <= pqs_pkg::UP_X_RESET;
      up_r[1]     <= pqs_pkg::UP_Y_RESET;
      up_r[2]     <= pqs_pkg::UP_Z_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (pqs_pkg::cfg_idx_t'(cfg_index))
          pqs_pkg::CFG_WIDTH: width_r <= cfg_data[pqs_pkg::WidthW-1:0];
          pqs_pkg::CFG_UP_X:  up_r[0] <= $signed(cfg_data);
          pqs_pkg::CFG_UP_Y:  up_r[1] <= $signed(cfg_data);
          default:            up_r[2] <= $signed(cfg_data);
        endcase
      end
      if (cmd.op == pqs_pkg::OP_EMIT) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p_r[0] <= $signed(in_point[CW-1:0]);
      p_r[1] <= $signed(in_point[2*CW-1:CW]);
      p_r[2] <= $signed(in_point[3*CW-1:2*CW]);
      fin_r  <= in_final;
    end
    prod_r <= prod_nxt;
    unique case (cmd.op)
      pqs_pkg::OP_LOAD_F: begin
        for (int i = 0; i < 3; i++) vin_r[i] <= VW'(p_r[i]) - VW'(prev_r[i]);
      end
      pqs_pkg::OP_LOAD_UP: begin
        for (int i = 0; i < 3; i++) vin_r[i] <= VW'(up_r[i]);
      end
      pqs_pkg::OP_LOAD_D0: begin
        for (int i = 0; i < 3; i++)
          vin_r[i] <= VW'(rof_r[i]) + VW'(pend_r[i]) - VW'(prev_r[i]);
      end
      pqs_pkg::OP_LOAD_D1: begin
        for (int i = 0; i < 3; i++)
          vin_r[i] <= VW'(pend_r[3+i]) - VW'(rof_r[i]) - VW'(prev_r[i]);
      end
      pqs_pkg::OP_ABS: begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= vin_r[i][VW-1];
          mag_r[i] <= vin_r[i][VW-1] ? MW'(-vin_r[i]) : MW'(vin_r[i]);
        end
      end
      pqs_pkg::OP_SCALE: begin
        // one bit a cycle toward a top magnitude in [2^29, 2^30)
        if (!scale_done) begin
          for (int i = 0; i < 3; i++) begin
            if (|or_m[MW-1:30]) mag_r[i] <= mag_r[i] >> 1;
            else mag_r[i] <= mag_r[i] << 1;
          end
        end
      end
      pqs_pkg::OP_SAVE_FS: begin
        for (int i = 0; i < 3; i++)
          fs_r[i] <= neg_r[i] ? -$signed({1'b0, mag_r[i][29:0]})
                              : $signed({1'b0, mag_r[i][29:0]});
      end
      pqs_pkg::OP_SAVE_US: begin
        for (int i = 0; i < 3; i++)
          us_r[i] <= neg_r[i] ? -$signed({1'b0, mag_r[i][29:0]})
                              : $signed({1'b0, mag_r[i][29:0]});
      end
      pqs_pkg::OP_CROSS_ACC: begin
        if (!cmd.idx[0]) vin_r[ck] <= prod_r;
        else vin_r[ck] <= vin_r[ck] - prod_r;
      end
      pqs_pkg::OP_SQ_ACC: begin
        sumsq_r <= ((k == 2'd0) ? 62'd0 : sumsq_r) + prod_r[61:0];
      end
      pqs_pkg::OP_SQRT_INIT: begin
        sqn_r   <= sumsq_r;
        sqres_r <= '0;
        sqbit_r <= 63'd1 << 62;
      end
      pqs_pkg::OP_SQRT_STEP: begin
        if ({2'b00, sqn_r} >= sq_try) begin
          sqn_r   <= sqn_r - sq_try[61:0];
          sqres_r <= (sqres_r >> 1) + sqbit_r;
        end else begin
          sqres_r <= sqres_r >> 1;
        end
        sqbit_r <= sqbit_r >> 2;
      end
      pqs_pkg::OP_DIV_INIT: begin
        rem_r <= {1'b0, mag_sel[29:0], 30'd0} + 61'(sqres_r[30:1]);
        den_r <= {sqres_r[30:0], 30'd0};
        q_r   <= '0;
      end
      pqs_pkg::OP_DIV_STEP: begin
        if (rem_r >= den_r) begin
          rem_r <= rem_r - den_r;
          q_r   <= {q_r[29:0], 1'b1};
        end else begin
          q_r   <= {q_r[29:0], 1'b0};
        end
        den_r <= den_r >> 1;
      end
      pqs_pkg::OP_DIV_STORE: begin
        u_r[k] <= neg_r[k] ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
      end
      pqs_pkg::OP_ZERO_U: begin
        for (int i = 0; i < 3; i++) u_r[i] <= '0;
      end
      pqs_pkg::OP_OFF_ACC: begin
        unique case (cmd.dst)
          pqs_pkg::DST_R: rof_r[k] <= CW'(off_sum >>> 31);
          pqs_pkg::DST_F: fof_r[k] <= CW'(off_sum >>> 31);
          default:        dof_r[k] <= CW'(off_sum >>> 31);
        endcase
      end
      pqs_pkg::OP_EMIT: begin
        for (int i = 0; i < 3; i++) overt_r[i] <= sat32(vsum[i]);
        oleft_r <= vleft;
        oend_r  <= vend;
      end
      pqs_pkg::OP_PEND: begin
        for (int i = 0; i < 3; i++) begin
          pend_r[i]   <= sat32(SW'(p_r[i]) + SW'(rof_r[i]));
          pend_r[3+i] <= sat32(SW'(p_r[i]) - SW'(rof_r[i]));
        end
      end
      pqs_pkg::OP_COMMIT: begin
        for (int i = 0; i < 3; i++) prev_r[i] <= p_r[i];
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_vert  = {overt_r[2], overt_r[1], overt_r[0]};
  assign out_left  = oleft_r;
  assign out_end   = oend_r;

endmodule

[rtl/pqs_checker.sv]
`timescale 1ns / 1ps

module pqs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [3*pqs_pkg::CoordW-1:0] out_tdata,
  input logic [0:0]                   out_tuser,
  input logic                         out_tlast
);

  // a stalled vertex holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled output item changed");

  // the strip closes on a left vertex
  a_end_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0])
    else $error("strip end on a right vertex");

  // no point is accepted in the cycle after an accepted one
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on back-to-back cycles");

  // reset leaves an empty, ready block
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind polyline_quad_strip_extruder pqs_checker u_pqs_checker (.*);
